@@ rtl/ckbc_pkg.sv @@
// ----------------------------------------------------------------------------
// ckbc_pkg: shared definitions for the colour-keyed sprite blitter
// Register codes, the configuration record, the queued word and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package ckbc_pkg;

	localparam int DISP_W_DEF  = 1280;
	localparam int DISP_H_DEF  = 720;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int COORD_W     = 12;
	localparam int COLOUR_W    = 32;
	localparam int OFFS_W      = 11;
	localparam int POS_W       = 14;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPRITE_WIDTH    = 3'd0,
		REG_SPRITE_HEIGHT   = 3'd1,
		REG_CENTRE_X        = 3'd2,
		REG_CENTRE_Y        = 3'd3,
		REG_KEY_COLOUR      = 3'd4,
		REG_SCREEN_OFFSET_X = 3'd5,
		REG_SCREEN_OFFSET_Y = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0]  sprite_width;
		logic [COORD_W-1:0]  sprite_height;
		logic [COORD_W-1:0]  centre_x;
		logic [COORD_W-1:0]  centre_y;
		logic [COLOUR_W-1:0] key_colour;
		logic [OFFS_W-1:0]   screen_offset_x;
		logic [OFFS_W-1:0]   screen_offset_y;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [COLOUR_W-1:0] colour;
	} blit_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

@@ rtl/colour_keyed_sprite_blit_clip.sv @@
// Path: an accepted visible pixel is written into the queue and then loaded into the output
// register, where it can be taken, unless earlier words still wait.
// Throughput: one pixel per cycle; the intake stalls only when the four-word queue
// is full, which happens only while the output side holds its stall.
// Reset: clears the configuration registers, the column and row counters, the queue pointers
// and count and the output valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// colour_keyed_sprite_blit_clip: colour-keyed sprite blit with clipping
// Places streamed sprite pixels on the display, skips keyed and clipped
// pixels and emits screen writes with the offset added.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_keyed_sprite_blit_clip #(
	parameter int DISP_W = ckbc_pkg::DISP_W_DEF,
	parameter int DISP_H = ckbc_pkg::DISP_H_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ckbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ckbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [ckbc_pkg::COLOUR_W-1:0]    pixel_colour,
	input  wire logic                             image_start,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [ckbc_pkg::COORD_W-1:0]          screen_x,
	output logic [ckbc_pkg::COORD_W-1:0]          screen_y,
	output logic [ckbc_pkg::COLOUR_W-1:0]         write_colour
);

	ckbc_pkg::cfg_t          cfg;
	ckbc_pkg::queue_status_t q_status;
	ckbc_pkg::blit_word_t    push_word;
	ckbc_pkg::blit_word_t    head_word;
	logic                    push;
	logic                    pop;

	ckbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ckbc_front #(
		.DISP_W (DISP_W),
		.DISP_H (DISP_H)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.pixel_colour (pixel_colour),
		.image_start  (image_start),
		.q_status     (q_status),
		.in_stall     (in_stall),
		.push         (push),
		.push_word    (push_word)
	);

	ckbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.q_status  (q_status)
	);

	ckbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_status     (q_status),
		.head_word    (head_word),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.write_colour (write_colour)
	);

endmodule

`default_nettype wire

@@ rtl/ckbc_cfg.sv @@
// ----------------------------------------------------------------------------
// ckbc_cfg: configuration registers
// Holds the sprite geometry, key colour and screen offsets written by software.
// ----------------------------------------------------------------------------
`default_nettype none

module ckbc_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ckbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ckbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ckbc_pkg::cfg_t                        cfg
);

	ckbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (ckbc_pkg::cfg_reg_t'(cfg_index))
				ckbc_pkg::REG_SPRITE_WIDTH: begin
					cfg_q.sprite_width <= cfg_data[ckbc_pkg::COORD_W-1:0];
				end
				ckbc_pkg::REG_SPRITE_HEIGHT: begin
					cfg_q.sprite_height <= cfg_data[ckbc_pkg::COORD_W-1:0];
				end
				ckbc_pkg::REG_CENTRE_X: begin
					cfg_q.centre_x <= cfg_data[ckbc_pkg::COORD_W-1:0];
				end
				ckbc_pkg::REG_CENTRE_Y: begin
					cfg_q.centre_y <= cfg_data[ckbc_pkg::COORD_W-1:0];
				end
				ckbc_pkg::REG_KEY_COLOUR: begin
					cfg_q.key_colour <= cfg_data[ckbc_pkg::COLOUR_W-1:0];
				end
				ckbc_pkg::REG_SCREEN_OFFSET_X: begin
					cfg_q.screen_offset_x <= cfg_data[ckbc_pkg::OFFS_W-1:0];
				end
				ckbc_pkg::REG_SCREEN_OFFSET_Y: begin
					cfg_q.screen_offset_y <= cfg_data[ckbc_pkg::OFFS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/ckbc_front.sv @@
// ----------------------------------------------------------------------------
// ckbc_front: pixel intake and classification
// Tracks column and row, places each pixel on the display and keeps only
// visible, non-keyed pixels, which are pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ckbc_front #(
	parameter int DISP_W = ckbc_pkg::DISP_W_DEF,
	parameter int DISP_H = ckbc_pkg::DISP_H_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ckbc_pkg::cfg_t                  cfg,
	input  wire logic                            in_valid,
	input  wire logic [ckbc_pkg::COLOUR_W-1:0]   pixel_colour,
	input  wire logic                            image_start,
	input  wire ckbc_pkg::queue_status_t         q_status,
	output logic                                 in_stall,
	output logic                                 push,
	output ckbc_pkg::blit_word_t                 push_word
);

	localparam int CW = ckbc_pkg::COORD_W;
	localparam int PW = ckbc_pkg::POS_W;
	localparam logic signed [PW-1:0] DISP_W_S = PW'(DISP_W);
	localparam logic signed [PW-1:0] DISP_H_S = PW'(DISP_H);
	localparam logic [CW-1:0]        DISP_W_U = CW'(DISP_W);
	localparam logic [CW-1:0]        DISP_H_U = CW'(DISP_H);

	logic [CW-1:0]        column_q;
	logic [CW-1:0]        row_q;
	logic [CW-1:0]        column_now;
	logic [CW-1:0]        row_now;
	logic [CW:0]          column_inc;
	logic [CW:0]          row_inc;
	logic signed [PW-1:0] xd;
	logic signed [PW-1:0] yd;
	logic                 accept;
	logic                 size_ok;
	logic                 emit;

	assign accept     = in_valid && !q_status.full;
	assign in_stall   = q_status.full;
	assign column_now = image_start ? '0 : column_q;
	assign row_now    = image_start ? '0 : row_q;
	assign column_inc = {1'b0, column_now} + (CW + 1)'(1);
	assign row_inc    = {1'b0, row_now} + (CW + 1)'(1);

	always_comb begin
		xd = $signed({2'b00, cfg.centre_x}) + $signed({2'b00, column_now})
			- $signed({3'b000, cfg.sprite_width[CW-1:1]});
		yd = $signed({2'b00, cfg.centre_y}) + $signed({2'b00, cfg.sprite_height})
			- $signed({2'b00, row_now}) - PW'(1)
			- $signed({3'b000, cfg.sprite_height[CW-1:1]});
		size_ok = (cfg.sprite_width != '0) && (cfg.sprite_height != '0)
			&& (cfg.sprite_width <= DISP_W_U) && (cfg.sprite_height <= DISP_H_U);
		emit = size_ok
			&& (column_now < cfg.sprite_width) && (row_now < cfg.sprite_height)
			&& (pixel_colour != cfg.key_colour)
			&& (xd >= 0) && (xd < DISP_W_S) && (yd >= 0) && (yd < DISP_H_S);
	end

	assign push             = accept && emit;
	assign push_word.x      = xd[CW-1:0];
	assign push_word.y      = yd[CW-1:0];
	assign push_word.colour = pixel_colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if ((cfg.sprite_width == '0) || (cfg.sprite_height == '0)) begin
				column_q <= '0;
				row_q    <= '0;
			end else if (column_inc >= {1'b0, cfg.sprite_width}) begin
				column_q <= '0;
				if (row_inc >= {1'b0, cfg.sprite_height}) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CW-1:0];
				end
			end else begin
				column_q <= column_inc[CW-1:0];
				row_q    <= row_now;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ckbc_queue.sv @@
// ----------------------------------------------------------------------------
// ckbc_queue: short word queue between intake and output
// A small circular buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ckbc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ckbc_pkg::blit_word_t push_word,
	input  wire logic                 pop,
	output ckbc_pkg::blit_word_t      head_word,
	output ckbc_pkg::queue_status_t   q_status
);

	localparam int PTR_W = ckbc_pkg::QPTR_W;
	localparam int CNT_W = ckbc_pkg::QCNT_W;

	ckbc_pkg::blit_word_t mem [ckbc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_status.full  = (count_q == CNT_W'(ckbc_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head_word      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ckbc_back.sv @@
// ----------------------------------------------------------------------------
// ckbc_back: screen write output stage
// Takes words from the queue, adds the screen offset and holds the result in
// the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ckbc_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ckbc_pkg::cfg_t                  cfg,
	input  wire ckbc_pkg::queue_status_t         q_status,
	input  wire ckbc_pkg::blit_word_t            head_word,
	output logic                                 pop,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [ckbc_pkg::COORD_W-1:0]         screen_x,
	output logic [ckbc_pkg::COORD_W-1:0]         screen_y,
	output logic [ckbc_pkg::COLOUR_W-1:0]        write_colour
);

	localparam int CW = ckbc_pkg::COORD_W;

	logic                              out_valid_q;
	logic [CW-1:0]                     screen_x_q;
	logic [CW-1:0]                     screen_y_q;
	logic [ckbc_pkg::COLOUR_W-1:0]     write_colour_q;

	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			screen_x_q     <= head_word.x + {1'b0, cfg.screen_offset_x};
			screen_y_q     <= head_word.y + {1'b0, cfg.screen_offset_y};
			write_colour_q <= head_word.colour;
		end
	end

	assign out_valid    = out_valid_q;
	assign screen_x     = screen_x_q;
	assign screen_y     = screen_y_q;
	assign write_colour = write_colour_q;

endmodule

`default_nettype wire

@@ rtl/ckbc_checker.sv @@
// ----------------------------------------------------------------------------
// ckbc_checker: port-level checks for the sprite blitter
// Watches the handshakes and the output word over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ckbc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic [ckbc_pkg::COORD_W-1:0]     screen_x,
	input wire logic [ckbc_pkg::COORD_W-1:0]     screen_y,
	input wire logic [ckbc_pkg::COLOUR_W-1:0]    write_colour
);

	// A stalled output word must stay offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(screen_x) && $stable(screen_y)
			&& $stable(write_colour))
		else $error("stalled output word changed");

	// The queue can only fill up behind a word that the output side is holding.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("intake stalled with no word waiting at the output");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("handshake active during reset");

endmodule

bind colour_keyed_sprite_blit_clip ckbc_checker u_checker (.*);

`default_nettype wire
